[rtl/core/lkxc_pkg.sv]
package lkxc_pkg;

    // Request codes carried in the command field.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Key bytes beyond this count are dropped until the next key start.
    localparam int unsigned MAX_KEY_LENGTH = 65535;
    localparam logic [15:0] MAX_WEIGHT     = 16'(MAX_KEY_LENGTH);

    typedef struct packed {
        logic       command;
        logic       key_start;
        logic [7:0] byte_in;
    } item_t;

    typedef struct packed {
        logic [31:0] state;
        logic [7:0]  ks;
    } lfsr_step_t;

    // Eight Fibonacci steps, taps 31/27/26/0, top bit collected MSB first.
    function automatic lfsr_step_t lfsr_byte(input logic [31:0] r);
        lfsr_step_t res;
        logic [31:0] s;
        s = r;
        res.ks = '0;
        for (int n = 0; n < 8; n++) begin
            res.ks[7-n] = s[31];
            s = {s[30:0], s[0] ^ s[26] ^ s[27] ^ s[31]};
        end
        res.state = s;
        return res;
    endfunction

endpackage

[rtl/core/lfsr_keystream_xor_cipher_unit.sv]
// LFSR keystream XOR cipher, one byte per request.
//
// Input channel (s_valid/s_ready): s_command selects the request kind.
// A key request (command 0) folds s_byte_in into the 32-bit seed with a
// position weight; s_key_start restarts the seed at zero and weight at one.
// Key requests produce no result. A data request (command 1) clocks the
// LFSR eight times and returns s_byte_in XOR the keystream byte on the
// result channel (m_valid/m_ready, m_byte_out). Encrypt and decrypt are
// the same operation.
//
// A data request passes the input register, then the result register,
// before its result is on m_byte_out for the receiver. Throughput: one
// request per cycle while the receiver does not stall data results.
// Reset (aresetn low, synchronous) empties both registers, clears the seed
// and sets the weight to one. When the receiver stalls, the result holds
// in the output register; key requests keep flowing, and a data request
// waits in the input register until the result slot frees.
module lfsr_keystream_xor_cipher_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic       s_key_start,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out
);
    import lkxc_pkg::*;

    item_t s_item;
    item_t item;
    logic  in_vld;
    logic  take;

    // Bundle the request fields for the input register.
    assign s_item = '{command: s_command, key_start: s_key_start, byte_in: s_byte_in};

    lkxc_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .take    (take),
        .in_vld  (in_vld),
        .item    (item)
    );

    // Seed accumulator, LFSR and result register.
    lkxc_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_vld     (in_vld),
        .item       (item),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_byte_out (m_byte_out)
    );

    // An accepted request lands in the input register.
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_vld)
        else $error("accepted request not captured");

    // A waiting request holds until the engine takes it.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld && !take) |=> (in_vld && $stable(item)))
        else $error("pending request lost or changed");

    // A taken data request always yields a result next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.command == CMD_DATA) |=> m_valid)
        else $error("data request produced no result");

    // A key request never raises an empty result slot.
    a_key_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.command == CMD_KEY && !m_valid) |=> !m_valid)
        else $error("key request produced a result");

endmodule

[rtl/core/lkxc_in_stage.sv]
module lkxc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lkxc_pkg::item_t   s_item,
    input  logic              take,
    output logic              in_vld,
    output lkxc_pkg::item_t   item
);
    import lkxc_pkg::*;

    logic  in_vld_reg;
    item_t item_reg;

    // Refill in the same cycle the engine drains the register.
    assign s_ready = !in_vld_reg || take;
    assign in_vld  = in_vld_reg;
    assign item    = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (take) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[rtl/core/lkxc_engine.sv]
module lkxc_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_vld,
    input  lkxc_pkg::item_t   item,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_byte_out
);
    import lkxc_pkg::*;

    logic [31:0] shift_reg, shift_next;
    logic [15:0] weight_reg, weight_next;
    logic        out_vld_reg, out_vld_next;
    logic [7:0]  out_byte_reg;

    logic [31:0] seed_base;
    logic [15:0] weight_base;
    logic [23:0] product;
    lfsr_step_t  step;
    logic        is_data;

    always_comb begin
        is_data = (item.command == CMD_DATA);
        // Key requests never touch the output register, so they pass a stall.
        take    = in_vld && (!is_data || !out_vld_reg || m_ready);

        seed_base   = item.key_start ? 32'd0 : shift_reg;
        weight_base = item.key_start ? 16'd1 : weight_reg;
        product     = {16'd0, item.byte_in} * {8'd0, weight_base};
        step        = lfsr_byte(shift_reg);

        shift_next  = shift_reg;
        weight_next = weight_reg;
        if (take) begin
            if (is_data) begin
                shift_next = step.state;
            end else begin
                shift_next = seed_base + {8'd0, product};
                if (weight_base == 16'd0 || weight_base >= MAX_WEIGHT) begin
                    weight_next = 16'd0;
                end else begin
                    weight_next = weight_base + 16'd1;
                end
            end
        end

        if (take && is_data) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg   <= 32'd0;
            weight_reg  <= 16'd1;
            out_vld_reg <= 1'b0;
        end else begin
            shift_reg   <= shift_next;
            weight_reg  <= weight_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && is_data) begin
            out_byte_reg <= item.byte_in ^ step.ks;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_byte_out = out_byte_reg;

endmodule

[test/tb_lfsr_keystream_xor_cipher_unit.sv]
`timescale 1ns / 100ps

module tb_lfsr_keystream_xor_cipher_unit;
    import lkxc_pkg::*;

    // The slowest correct run is the long key plus about 1200 requests that
    // each wait out the longest sender gap and the longest receiver stall.
    // The cap below is several times that.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // A data result passes the input register and the result register before
    // it can be taken; give it ample slack.
    localparam int unsigned DRAIN_CYCLES = 20;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_command   = CMD_KEY;
    logic       s_key_start = 1'b0;
    logic [7:0] s_byte_in   = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_byte_out;

    // Cipher state as the testbench expects it to be after every accepted
    // request: the LFSR / seed accumulator and the weight of the next key byte.
    logic [31:0] lfsr_model   = 32'h0;
    logic [15:0] weight_model = 16'd1;
    // Cipher bytes still owed by the block, oldest first.
    logic [7:0]  expected_bytes[$];
    logic [7:0]  expected_head;

    // Idling controls, switched per test.
    bit          send_gaps   = 1'b0;
    bit          recv_stalls = 1'b0;
    int unsigned stall_left  = 0;

    int unsigned key_count     = 0;
    int unsigned data_count    = 0;
    int unsigned checked_count = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    lfsr_keystream_xor_cipher_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_key_start (s_key_start),
        .s_byte_in   (s_byte_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_byte_out  (m_byte_out)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop if the block hangs or stops answering.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still owed",
                     $time, cycle_count, expected_bytes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Idle length: mostly none, often a few cycles, now and then a long stretch.
    function automatic int unsigned pick_gap(input bit enable);
        int unsigned pick;
        if (!enable)
            return 0;
        pick = $urandom_range(99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 6);
    endfunction

    // Advance the expected cipher state by one accepted request. A key byte
    // folds into the seed with its position weight; a data byte clocks the
    // LFSR eight times and queues the byte the block must return.
    task automatic model_request(input logic cmd, input logic start, input logic [7:0] octet);
        logic [7:0] keystream;
        logic       feedback;
        if (cmd == CMD_KEY) begin
            key_count++;
            // Restart the seed on key start.
            if (start) begin
                lfsr_model   = 32'h0;
                weight_model = 16'd1;
            end
            // Weight zero means the key ran too long: the byte adds nothing.
            lfsr_model = lfsr_model + 32'(octet) * 32'(weight_model);
            if (weight_model != 16'd0) begin
                if (weight_model >= 16'(MAX_KEY_LENGTH))
                    weight_model = 16'd0;
                else
                    weight_model = weight_model + 16'd1;
            end
        end else begin
            data_count++;
            keystream = 8'h00;
            // Collect the top bit MSB first, then shift left with feedback
            // from taps 0, 26, 27 and 31 into bit 0.
            for (int n = 0; n < 8; n++) begin
                keystream  = {keystream[6:0], lfsr_model[31]};
                feedback   = lfsr_model[0] ^ lfsr_model[26] ^ lfsr_model[27] ^ lfsr_model[31];
                lfsr_model = {lfsr_model[30:0], feedback};
            end
            expected_bytes.push_back(octet ^ keystream);
        end
    endtask

    // Offer one request and return at the edge that accepts it. Valid drops
    // only when a gap comes first, so back-to-back requests keep it high.
    // While valid is low, scramble the payload to catch a block that
    // samples it outside the handshake.
    task automatic send_request(input logic cmd, input logic start, input logic [7:0] octet);
        int unsigned gap;
        gap = pick_gap(send_gaps);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) begin
                s_command   <= 1'($urandom);
                s_key_start <= 1'($urandom);
                s_byte_in   <= 8'($urandom);
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_key_start <= start;
        s_byte_in   <= octet;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        model_request(cmd, start, octet);
    endtask

    // Receiver: hold ready low for a random stretch, then take one result.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap(recv_stalls);
        end
    end

    // Compare every accepted result with the oldest owed cipher byte.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                error_count++;
                $display("%0t: byte_out %02h arrived with no data request pending",
                         $time, m_byte_out);
            end else begin
                expected_head = expected_bytes.pop_front();
                checked_count++;
                if (m_byte_out !== expected_head) begin
                    error_count++;
                    $display("%0t: byte_out expected %02h, actual %02h",
                             $time, expected_head, m_byte_out);
                end
            end
        end
    end

    // Data straight after reset: the register is zero, so the keystream is
    // all zero and bytes pass through unchanged.
    task automatic test_data_before_key();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        send_request(CMD_DATA, 1'b0, 8'h00);
        send_request(CMD_DATA, 1'b1, 8'hFF);
        send_request(CMD_DATA, 1'b0, 8'h5A);
    endtask

    // Extreme octets in the seed, a key continued without start, and a
    // restart that seeds with zero.
    task automatic test_key_extremes();
        send_gaps   = 1'b0;
        recv_stalls = 1'b1;
        send_request(CMD_KEY, 1'b1, 8'hFF);
        send_request(CMD_KEY, 1'b0, 8'h00);
        send_request(CMD_KEY, 1'b0, 8'hFF);
        send_request(CMD_DATA, 1'b0, 8'h00);
        send_request(CMD_DATA, 1'b0, 8'hFF);
        send_request(CMD_DATA, 1'b0, 8'h3C);
        send_request(CMD_KEY, 1'b1, 8'h00);
        send_request(CMD_DATA, 1'b0, 8'hFF);
    endtask

    // A key byte without start lands on a register that data has already
    // clocked; key start on a data request must be ignored.
    task automatic test_key_continuation();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_request(CMD_KEY, 1'b1, 8'h81);
        send_request(CMD_DATA, 1'b0, 8'h00);
        send_request(CMD_DATA, 1'b0, 8'h00);
        send_request(CMD_KEY, 1'b0, 8'h7E);
        send_request(CMD_DATA, 1'b0, 8'hC3);
        send_request(CMD_DATA, 1'b1, 8'h00);
        send_request(CMD_DATA, 1'b0, 8'h11);
    endtask

    // Run the weight all the way out: after the maximum key length the extra
    // key bytes are dropped, also without start after data, until a new
    // key start brings the weight back.
    task automatic test_long_key();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        send_request(CMD_KEY, 1'b1, 8'hFF);
        repeat (MAX_KEY_LENGTH + 2)
            send_request(CMD_KEY, 1'b0, 8'($urandom));
        send_request(CMD_DATA, 1'b0, 8'hA5);
        send_request(CMD_DATA, 1'b0, 8'h00);
        send_request(CMD_KEY, 1'b0, 8'hFF);
        send_request(CMD_DATA, 1'b0, 8'hFF);
        send_request(CMD_KEY, 1'b1, 8'h42);
        send_request(CMD_DATA, 1'b0, 8'h42);
    endtask

    // Mostly proper sessions (key start, a short key, a run of data) with
    // random content; the rest is loose requests of either kind.
    task automatic test_random_sessions(input int unsigned n_items, input bit gaps,
                                        input bit stalls);
        int unsigned sent;
        int unsigned key_len;
        int unsigned data_len;
        send_gaps   = gaps;
        recv_stalls = stalls;
        sent        = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                key_len  = $urandom_range(12, 1);
                data_len = $urandom_range(24, 1);
                send_request(CMD_KEY, 1'b1, 8'($urandom));
                for (int k = 1; k < key_len; k++)
                    send_request(CMD_KEY, 1'b0, 8'($urandom));
                for (int d = 0; d < data_len; d++)
                    send_request(CMD_DATA, 1'($urandom), 8'($urandom));
                sent += key_len + data_len;
            end else begin
                data_len = $urandom_range(6, 1);
                for (int d = 0; d < data_len; d++)
                    send_request(1'($urandom) ? CMD_DATA : CMD_KEY, 1'($urandom),
                                 8'($urandom));
                sent += data_len;
            end
        end
    endtask

    initial begin
        // Hold reset, then release it once.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_data_before_key();
        test_key_extremes();
        test_key_continuation();
        test_long_key();
        test_random_sessions(200, 1'b0, 1'b0);
        test_random_sessions(700, 1'b1, 1'b1);
        test_random_sessions(300, 1'b0, 1'b1);

        // Drop valid, drain the owed results, then let stray output show up.
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d key bytes and %0d data bytes; %0d cipher bytes compared.",
                 key_count, data_count, checked_count);
        $display("Covered plaintext before keying, extreme octets, key overrun and random sessions.");
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[lfsr_keystream_xor_cipher_unit.f]
rtl/core/lkxc_pkg.sv
rtl/core/lkxc_in_stage.sv
rtl/core/lkxc_engine.sv
rtl/core/lfsr_keystream_xor_cipher_unit.sv
test/tb_lfsr_keystream_xor_cipher_unit.sv
